>>> rtl/qpsm_pkg.sv
// ----------------------------------------------------------------------------
// qpsm_pkg
// Shared types, constants and helpers of the quadrature position and speed
// meter.
// ----------------------------------------------------------------------------
package qpsm_pkg;

   localparam int EDGE_COUNT_BITS = 16;
   localparam int COUNT_BITS      = 32;
   localparam int VEL_GAIN_BITS   = 24;
   localparam int POS_GAIN_BITS   = 20;
   localparam int SPEED_BITS      = 24;
   localparam int FRAC_BITS       = 16;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 24;

   localparam int SPEED_PROD_BITS = EDGE_COUNT_BITS + VEL_GAIN_BITS;
   localparam int POS_PROD_BITS   = COUNT_BITS + POS_GAIN_BITS;
   localparam int POS_QUOT_BITS   = POS_PROD_BITS - FRAC_BITS;

   localparam logic [VEL_GAIN_BITS-1:0] VEL_GAIN_RESET = VEL_GAIN_BITS'(592104);
   localparam logic [POS_GAIN_BITS-1:0] POS_GAIN_RESET = POS_GAIN_BITS'(5610);
   localparam logic [SPEED_BITS-1:0]    SPEED_MAX      = '1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_VEL_GAIN = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POS_GAIN = CSR_INDEX_BITS'(1);

   typedef enum logic {
      CMD_EDGE = 1'b0,
      CMD_TICK = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    chan_a;
      logic    chan_b;
   } req_type;

   typedef struct packed {
      logic signed [COUNT_BITS-1:0] raw_count;
      logic signed [COUNT_BITS-1:0] scaled_position;
      logic [SPEED_BITS-1:0]        speed;
   } rsp_type;

   typedef struct packed {
      logic                         valid;
      logic signed [COUNT_BITS-1:0] count;
      logic [SPEED_BITS-1:0]        speed;
   } track_type;

   // Predecessor of each state in the forward cycle 0,2,3,1.
   function automatic logic [1:0] forward_prev(input logic [1:0] ab);
      logic [1:0] prev;
      case (ab)
         2'd0:    prev = 2'd1;
         2'd1:    prev = 2'd3;
         2'd2:    prev = 2'd0;
         default: prev = 2'd2;
      endcase
      return prev;
   endfunction

endpackage

>>> rtl/qpsm_if.sv
// ----------------------------------------------------------------------------
// qpsm_req_if / qpsm_rsp_if
// Valid/ready channels carrying request and result items.
// ----------------------------------------------------------------------------
interface qpsm_req_if;
   import qpsm_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface qpsm_rsp_if;
   import qpsm_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/qpsm_track.sv
// ----------------------------------------------------------------------------
// qpsm_track
// Decoder state: quadrature count, window edge counter and speed latch,
// updated once per accepted item.
// ----------------------------------------------------------------------------
module qpsm_track (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    accept,
   input  qpsm_pkg::req_type                       item,
   input  logic                                    advance,
   input  logic [qpsm_pkg::VEL_GAIN_BITS-1:0]      vel_gain,
   output qpsm_pkg::track_type                     track
);
   import qpsm_pkg::*;

   logic                         valid_ff, valid_in;
   logic [1:0]                   last_ab_ff, last_ab_in;
   logic signed [COUNT_BITS-1:0] count_ff, count_in;
   logic [EDGE_COUNT_BITS-1:0]   edges_ff, edges_in;
   logic [SPEED_BITS-1:0]        speed_ff, speed_in;
   logic [1:0]                   ab;
   logic [SPEED_PROD_BITS-1:0]   speed_prod;
   logic [SPEED_PROD_BITS-1:0]   speed_quot;

   assign ab         = {item.chan_a, item.chan_b};
   assign speed_prod = SPEED_PROD_BITS'(edges_ff) * SPEED_PROD_BITS'(vel_gain);
   assign speed_quot = speed_prod >> FRAC_BITS;

   always_comb begin
      valid_in   = accept ? 1'b1 : (advance ? 1'b0 : valid_ff);
      last_ab_in = last_ab_ff;
      count_in   = count_ff;
      edges_in   = edges_ff;
      speed_in   = speed_ff;
      if (accept) begin
         case (item.cmd)
            CMD_EDGE: begin
               last_ab_in = ab;
               count_in   = (last_ab_ff == forward_prev(ab)) ? count_ff + COUNT_BITS'(1)
                                                              : count_ff - COUNT_BITS'(1);
               if (edges_ff != '1) begin
                  edges_in = edges_ff + 1'b1;
               end
            end
            CMD_TICK: begin
               edges_in = '0;
               speed_in = (speed_quot > SPEED_PROD_BITS'(SPEED_MAX)) ? SPEED_MAX
                                                                    : speed_quot[SPEED_BITS-1:0];
            end
            default: begin
               edges_in = edges_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         last_ab_ff <= '0;
         count_ff   <= '0;
         edges_ff   <= '0;
         speed_ff   <= '0;
      end else begin
         valid_ff   <= valid_in;
         last_ab_ff <= last_ab_in;
         count_ff   <= count_in;
         edges_ff   <= edges_in;
         speed_ff   <= speed_in;
      end
   end

   assign track.valid = valid_ff;
   assign track.count = count_ff;
   assign track.speed = speed_ff;

endmodule

>>> rtl/qpsm_scale.sv
// ----------------------------------------------------------------------------
// qpsm_scale
// Scales the count by the position gain and holds the result item.
// ----------------------------------------------------------------------------
module qpsm_scale (
   input  logic                                 clock,
   input  logic                                 reset,
   input  qpsm_pkg::track_type                  track,
   input  logic [qpsm_pkg::POS_GAIN_BITS-1:0]   pos_gain,
   output logic                                 advance,
   qpsm_rsp_if.source                           rsp
);
   import qpsm_pkg::*;

   logic                       valid_ff, valid_in;
   rsp_type                    result_ff;
   logic                       neg;
   logic [COUNT_BITS-1:0]      mag;
   logic [POS_PROD_BITS-1:0]   prod;
   logic [POS_QUOT_BITS-1:0]   quot;
   logic [COUNT_BITS-1:0]      pos_lim;
   logic [COUNT_BITS-1:0]      scaled;

   assign neg  = track.count[COUNT_BITS-1];
   assign mag  = neg ? COUNT_BITS'(-track.count) : COUNT_BITS'(track.count);
   assign prod = POS_PROD_BITS'(mag) * POS_PROD_BITS'(pos_gain);
   assign quot = prod[POS_PROD_BITS-1:FRAC_BITS];

   always_comb begin
      if (neg) begin
         pos_lim = {1'b1, {(COUNT_BITS-1){1'b0}}};
      end else begin
         pos_lim = {1'b0, {(COUNT_BITS-1){1'b1}}};
      end
      if (quot > POS_QUOT_BITS'(pos_lim)) begin
         scaled = pos_lim;
      end else begin
         scaled = quot[COUNT_BITS-1:0];
      end
      if (neg) begin
         scaled = -scaled;
      end
   end

   assign advance  = !valid_ff || rsp.ready;
   assign valid_in = advance ? track.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && track.valid) begin
         result_ff.raw_count       <= track.count;
         result_ff.scaled_position <= $signed(scaled);
         result_ff.speed           <= track.speed;
      end
   end

   assign rsp.valid   = valid_ff;
   assign rsp.payload = result_ff;

endmodule

>>> rtl/quadrature_position_speed_meter.sv
// ----------------------------------------------------------------------------
// quadrature_position_speed_meter
// x4 quadrature decoder with scaled position and windowed speed.
//
// req_ch carries one item per edge sample (cmd edge, with chan_a/chan_b
// levels) or per end-of-window tick. Each item gives one result item on
// rsp_ch: raw count, scaled position and latched speed after the update.
// The csr_ port writes vel_gain (index 0) and pos_gain (index 1); other
// indexes are dropped. Write only while no item is in flight.
// The accepting edge loads the state update register; the result register
// behind the position multiplier takes the item once it is free and drives
// rsp_ch.valid, so an accepted item passes both registers before it leaves.
// Throughput is one item per cycle while rsp_ch.ready stays high.
// Reset clears count, previous state, edge counter, speed and both valid
// stages, and loads the default gains.
// When the receiver stalls, the result holds and one more item is taken
// into the state stage; req_ch.ready then drops until the result leaves.
// ----------------------------------------------------------------------------
module quadrature_position_speed_meter (
   input  logic                                   clock,
   input  logic                                   reset,
   qpsm_req_if.sink                               req_ch,
   qpsm_rsp_if.source                             rsp_ch,
   input  logic                                   csr_we,
   input  logic [qpsm_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [qpsm_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import qpsm_pkg::*;

   logic [VEL_GAIN_BITS-1:0] vel_gain_ff;
   logic [POS_GAIN_BITS-1:0] pos_gain_ff;
   logic                     accept;
   logic                     advance;
   track_type                track;

   always_ff @(posedge clock) begin
      if (reset) begin
         vel_gain_ff <= VEL_GAIN_RESET;
         pos_gain_ff <= POS_GAIN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VEL_GAIN: vel_gain_ff <= csr_wdata[VEL_GAIN_BITS-1:0];
            CSR_POS_GAIN: pos_gain_ff <= csr_wdata[POS_GAIN_BITS-1:0];
            default:      vel_gain_ff <= vel_gain_ff;
         endcase
      end
   end

   assign req_ch.ready = !track.valid || advance;
   assign accept       = req_ch.valid && req_ch.ready;

   qpsm_track u_track (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .item     (req_ch.payload),
      .advance  (advance),
      .vel_gain (vel_gain_ff),
      .track    (track)
   );

   qpsm_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .track    (track),
      .pos_gain (pos_gain_ff),
      .advance  (advance),
      .rsp      (rsp_ch)
   );

   a_edge_steps: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.payload.cmd == CMD_EDGE |=>
         track.count == $past(track.count) + COUNT_BITS'(1) ||
         track.count == $past(track.count) - COUNT_BITS'(1))
      else $error("edge item did not step the count by one");

   a_tick_holds_count: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.payload.cmd == CMD_TICK |=> $stable(track.count))
      else $error("tick item changed the count");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> track.valid)
      else $error("accepted item lost from state stage");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      track.valid && rsp_ch.valid && !rsp_ch.ready |-> !req_ch.ready)
      else $error("item taken while both stages are full");

endmodule
